// ===== design/lrde_pkg.sv =====
package lrde_pkg;

  localparam int HW_W     = 4;   // window half-width register
  localparam int CENTER_W = 5;   // center index field
  localparam int LINE_W   = 32;  // sensor bits carried by the input
  localparam int ANGLE_W  = 16;  // angle in turn fractions, 65536 = one turn
  localparam int TRIG_W   = 16;  // signed Q1.14 sine / cosine
  localparam int SUM_W    = 20;  // up to 31 vectors of magnitude 2^14
  localparam int CORDIC_W = 32;  // sums scaled by 256 plus CORDIC growth
  localparam int STEP_W   = 5;   // CORDIC step index, table depth 24
  localparam int POS_W    = 6;   // sensor angle in 1/64 turn

  localparam logic [ANGLE_W-1:0] HALF_TURN = 16'h8000;

  // round(16384 * sin(k * pi / 32)), k = 0..16
  localparam logic [14:0] QUARTER_SINE [17] = '{
    15'd0,     15'd1606,  15'd3196,  15'd4756,  15'd6270,  15'd7723,
    15'd9102,  15'd10394, 15'd11585, 15'd12665, 15'd13623, 15'd14449,
    15'd15137, 15'd15679, 15'd16069, 15'd16305, 15'd16384
  };

  // round(atan(2^-i) * 65536 / (2 * pi))
  localparam logic [ANGLE_W-1:0] ATAN_TURN [24] = '{
    16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326,
    16'd163,  16'd81,   16'd41,   16'd20,   16'd10,  16'd5,
    16'd3,    16'd1,    16'd1,    16'd0,    16'd0,   16'd0,
    16'd0,    16'd0,    16'd0,    16'd0,    16'd0,   16'd0
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACCUM,
    S_LAUNCH,
    S_CORDIC,
    S_OUT
  } lrde_state_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [ANGLE_W-1:0] angle;
  } lrde_cordic_stat_t;

  // sine in Q1.14 of p/64 turn
  function automatic logic signed [TRIG_W-1:0] sine64(input logic [POS_W-1:0] p);
    logic [1:0]  q;
    logic [3:0]  r;
    logic [14:0] v;
    q = p[5:4];
    r = p[3:0];
    v = q[0] ? QUARTER_SINE[5'd16 - {1'b0, r}] : QUARTER_SINE[{1'b0, r}];
    return q[1] ? -signed'({1'b0, v}) : signed'({1'b0, v});
  endfunction

endpackage

// ===== design/lrde_cordic.sv =====
module lrde_cordic
  import lrde_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [CORDIC_W-1:0] x_in,
  input  logic signed [CORDIC_W-1:0] y_in,
  output lrde_cordic_stat_t          stat
);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  logic signed [CORDIC_W-1:0] x_r, x_nxt;
  logic signed [CORDIC_W-1:0] y_r, y_nxt;
  logic [ANGLE_W-1:0]         z_r, z_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic                       zero_r, zero_nxt;
  logic signed [CORDIC_W-1:0] dx, dy;

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    zero_nxt = zero_r;
    dx       = y_r >>> step_r;
    dy       = x_r >>> step_r;
    if (start) begin
      zero_nxt = (x_in == '0) && (y_in == '0);
      step_nxt = '0;
      busy_nxt = 1'b1;
      // left half plane: rotate by half a turn first
      if (x_in < 0) begin
        x_nxt = -x_in;
        y_nxt = -y_in;
        z_nxt = HALF_TURN;
      end else begin
        x_nxt = x_in;
        y_nxt = y_in;
        z_nxt = '0;
      end
    end else if (busy_r) begin
      if (y_r > 0) begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + ATAN_TURN[step_r];
      end else begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - ATAN_TURN[step_r];
      end
      step_nxt = step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    step_r <= step_nxt;
    zero_r <= zero_nxt;
  end

  assign stat = '{busy: busy_r, done: done_r, angle: (zero_r ? '0 : z_r)};

endmodule

// ===== design/line_ring_direction_estimator_core.sv =====
// Input transaction to result valid: sweep of the 2*W + 1 window sensors, CORDIC run,
//   hand-off, W = window_half_width; without a sighting in the window, no CORDIC run.
// A new transaction is taken only once the sequencer is idle again; one sensor is
//   summed per cycle, then the shared CORDIC add/shift unit runs one step per cycle.
// A waiting result sits in the output register while the next input is taken.
// Reset (rst_n low, synchronous): sequencer idle, output empty, window_half_width = 7.
module line_ring_direction_estimator_core
  import lrde_pkg::*;
#(
  parameter int NUM_SENSORS  = 32,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] sensor_bits, [36:32] center_index, [39:37] zero
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] direction_angle
  output logic [0:0]  out_tuser,  // [0] direction_found
  // configuration
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data // window_half_width
);

  localparam int IDX_W = $clog2(NUM_SENSORS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SENSORS - 1);

  // sensor angle in 1/64 turn, round(k * 64 / NUM_SENSORS) mod 64
  function automatic logic [NUM_SENSORS*POS_W-1:0] build_pos_lut();
    logic [NUM_SENSORS*POS_W-1:0] t;
    t = '0;
    for (int k = 0; k < NUM_SENSORS; k++) begin
      t[k*POS_W +: POS_W] = POS_W'((k * 64 + NUM_SENSORS / 2) / NUM_SENSORS);
    end
    return t;
  endfunction

  localparam logic [NUM_SENSORS*POS_W-1:0] POS_LUT = build_pos_lut();

  lrde_state_t          state_r, state_nxt;
  logic [HW_W-1:0]      hw_r;
  logic [LINE_W-1:0]    line_r, line_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [4:0]           cnt_r, cnt_nxt;      // sensors left in the window, at most 31
  logic signed [SUM_W-1:0] xs_r, xs_nxt;
  logic signed [SUM_W-1:0] ys_r, ys_nxt;
  logic                 found_r, found_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r, out_found_nxt;
  logic [ANGLE_W-1:0]   out_angle_r, out_angle_nxt;

  logic                 in_fire;
  logic                 cordic_start;
  lrde_cordic_stat_t    cordic_stat;
  logic [6:0]           center_mod;
  logic signed [7:0]    start_pos;
  logic [6:0]           idx_ext;
  logic                 seen;
  logic [POS_W-1:0]     pos;
  logic signed [TRIG_W-1:0] cos_v, sin_v;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // Window start: center reduced modulo the ring, then stepped back by the half-width.
  always_comb begin
    center_mod = 7'(in_tdata[36:32]);
    for (int k = 0; k < 4; k++) begin
      if (center_mod >= 7'(NUM_SENSORS)) center_mod = center_mod - 7'(NUM_SENSORS);
    end
    start_pos = signed'({1'b0, center_mod}) - signed'({4'b0, hw_r});
    // half-width is at most 15; the ring must have at least 8 sensors, which the block does not enforce
    if (start_pos < 0) start_pos = start_pos + 8'(NUM_SENSORS);
    if (start_pos < 0) start_pos = start_pos + 8'(NUM_SENSORS);
  end

  // Current sensor: positions beyond the input's 32 bits read as no line.
  assign idx_ext = 7'(idx_r);
  assign seen    = (idx_ext < 7'd32) && !line_r[idx_ext[4:0]];
  assign pos     = POS_LUT[32'(idx_r) * POS_W +: POS_W];
  assign sin_v   = sine64(pos);
  assign cos_v   = sine64(pos + 6'd16);

  // Sequencer: sum one sensor per cycle, CORDIC if any seen, wait, hand off result.
  always_comb begin
    state_nxt     = state_r;
    line_nxt      = line_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    xs_nxt        = xs_r;
    ys_nxt        = ys_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_angle_nxt = out_angle_r;
    cordic_start  = 1'b0;

    // drop the result once the downstream takes it
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          line_nxt  = in_tdata[31:0];
          idx_nxt   = IDX_W'(start_pos);
          cnt_nxt   = {hw_r, 1'b1};   // 2 * hw + 1 sensors
          xs_nxt    = '0;
          ys_nxt    = '0;
          found_nxt = 1'b0;
          state_nxt = S_ACCUM;
        end
      end
      S_ACCUM: begin
        if (seen) begin
          xs_nxt    = xs_r + SUM_W'(cos_v);
          ys_nxt    = ys_r + SUM_W'(sin_v);
          found_nxt = 1'b1;
        end
        idx_nxt = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == 5'd1) begin
          state_nxt = (found_r || seen) ? S_LAUNCH : S_OUT;
        end
      end
      S_LAUNCH: begin
        cordic_start = 1'b1;
        state_nxt    = S_CORDIC;
      end
      S_CORDIC: begin
        if (cordic_stat.done) state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free or being emptied
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          out_angle_nxt = found_r ? cordic_stat.angle : '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  lrde_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .x_in  (CORDIC_W'($signed({xs_r, 8'h00}))),
    .y_in  (CORDIC_W'($signed({ys_r, 8'h00}))),
    .stat  (cordic_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      hw_r        <= 4'd7;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) hw_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    line_r      <= line_nxt;
    idx_r       <= idx_nxt;
    cnt_r       <= cnt_nxt;
    xs_r        <= xs_nxt;
    ys_r        <= ys_nxt;
    found_r     <= found_nxt;
    out_found_r <= out_found_nxt;
    out_angle_r <= out_angle_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_angle_r;
  assign out_tuser  = out_found_r;

`ifndef SYNTHESIS
  // the CORDIC unit only runs while the sequencer waits for it
  a_cordic_owned: assert property (@(posedge clk) disable iff (!rst_n)
    cordic_stat.busy |-> (state_r == S_CORDIC))
    else $error("CORDIC busy outside its wait state");

  // a result without a sighting carries angle zero
  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0))
    else $error("not-found result with nonzero angle");

  // an accepted transaction starts the window sweep next cycle
  a_accept_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_ACCUM) && (cnt_r == {$past(hw_r), 1'b1}))
    else $error("window sweep not started after accept");

  // a launch is only issued with at least one sighting
  a_launch_found: assert property (@(posedge clk) disable iff (!rst_n)
    cordic_start |-> found_r)
    else $error("CORDIC launched with nothing seen");
`endif

endmodule
